// ===== sv/stia_pkg.sv =====
// Shared types, codes and helper functions for the sized typed integer ALU.
package stia_pkg;

  // Operation codes
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_DIV  = 5'd3,
    OP_MOD  = 5'd4,
    OP_AND  = 5'd5,
    OP_OR   = 5'd6,
    OP_XOR  = 5'd7,
    OP_SHR  = 5'd8,
    OP_SHL  = 5'd9,
    OP_GT   = 5'd10,
    OP_GE   = 5'd11,
    OP_LT   = 5'd12,
    OP_LE   = 5'd13,
    OP_EQ   = 5'd14,
    OP_LAND = 5'd15,
    OP_LOR  = 5'd16,
    OP_NOT  = 5'd17
  } op_t;

  // Operand type codes
  localparam logic [1:0] TY_UNS  = 2'd0;
  localparam logic [1:0] TY_SGN  = 2'd1;
  localparam logic [1:0] TY_ENUM = 2'd2;
  localparam logic [1:0] TY_BAD  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIVZ  = 2'd1;
  localparam logic [1:0] ST_UNDEF = 2'd2;

  localparam int DIV_STEPS = 64;

  // Decode stage contents
  typedef struct packed {
    op_t         func;
    logic [63:0] a;
    logic [63:0] b;
    logic        any_sig;
    logic        both_sig;
    logic [3:0]  sz;
    logic        undef;
  } dec_t;

  // Execute stage contents
  typedef struct packed {
    op_t         func;
    logic        any_sig;
    logic [3:0]  sz;
    logic        undef;
    logic        divz;
    logic        neg_q;
    logic        neg_r;
    logic [63:0] res;
    logic [63:0] pp_ll;
    logic [31:0] pp_lh;
    logic [31:0] pp_hl;
    logic [63:0] ma;
    logic [63:0] mb;
  } exe_t;

  // Divider stage contents
  typedef struct packed {
    op_t         func;
    logic        any_sig;
    logic [3:0]  sz;
    logic        undef;
    logic        divz;
    logic        neg_q;
    logic        neg_r;
    logic [63:0] res;
    logic [63:0] rem;
    logic [63:0] quo;
    logic [63:0] dvs;
  } dv_t;

  // Mask of the low sz bytes
  function automatic logic [63:0] size_mask(input logic [3:0] sz);
    if (sz >= 4'd8) return '1;
    return ~({64{1'b1}} << {sz[2:0], 3'b000});
  endfunction

  // Sign-extend from sz bytes
  function automatic logic [63:0] sign_ext(input logic [63:0] v, input logic [3:0] sz);
    logic [63:0] m;
    logic [5:0]  top;
    m   = size_mask(sz);
    top = {sz[2:0], 3'b000} - 6'd1;
    if (sz >= 4'd8) return v;
    return v[top] ? (v | ~m) : (v & m);
  endfunction

  // Size 0 acts as 1, above 8 acts as 8
  function automatic logic [3:0] clamp_size(input logic [3:0] s);
    if (s == 4'd0) return 4'd1;
    if (s > 4'd8) return 4'd8;
    return s;
  endfunction

  // One restoring division step: one quotient bit
  function automatic dv_t div_step(input dv_t s);
    logic [64:0] t;
    logic [64:0] diff;
    dv_t         o;
    o    = s;
    t    = {s.rem, s.quo[63]};
    diff = t - {1'b0, s.dvs};
    if (!diff[64]) begin
      o.rem = diff[63:0];
      o.quo = {s.quo[62:0], 1'b1};
    end else begin
      o.rem = t[63:0];
      o.quo = {s.quo[62:0], 1'b0};
    end
    return o;
  endfunction

endpackage

// ===== sv/sized_typed_integer_alu_unit.sv =====
// Sized typed integer ALU: a 67-stage pipeline taking one transaction per clock.
//
// Every transaction leaves exactly 67 clock cycles after it is taken (when the
// output side does not stall), and a new one may be taken in every cycle. The
// latency is set by the divider: a restoring divider of 64 register stages, one
// quotient bit each, behind a decode stage and an execute stage (simple ops and
// 32-bit partial products of the multiplier), with the output register last.
// Every operation travels the same path, so results leave in order. When the
// output is held, the whole pipeline holds.
module sized_typed_integer_alu_unit
  import stia_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // func[4:0], lhs_value[68:5], lhs_type[70:69], lhs_size[74:71],
  // rhs_value[138:75], rhs_type[140:139], rhs_size[144:141], zero pad
  input  logic [151:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_value[63:0], result_signed[64], result_size[68:65], status[70:69], pad
  output logic [71:0]  out_tdata
);

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- decode: canonicalise operands
  logic [4:0]  f_raw;
  logic [1:0]  lt, rt;
  logic [3:0]  ls, rs;
  logic [63:0] lv, rv;
  dec_t        dec_nxt, dec_r;
  logic        dec_v_r;

  always_comb begin
    f_raw = in_tdata[4:0];
    lv    = in_tdata[68:5];
    lt    = in_tdata[70:69];
    ls    = clamp_size(in_tdata[74:71]);
    rv    = in_tdata[138:75];
    rt    = in_tdata[140:139];
    rs    = clamp_size(in_tdata[144:141]);
    if (lt == TY_ENUM) ls = 4'd8;
    if (rt == TY_ENUM) rs = 4'd8;
    dec_nxt.func = op_t'(f_raw);
    case (lt)
      TY_SGN:  dec_nxt.a = sign_ext(lv, ls);
      TY_ENUM: dec_nxt.a = lv;
      default: dec_nxt.a = lv & size_mask(ls);
    endcase
    case (rt)
      TY_SGN:  dec_nxt.b = sign_ext(rv, rs);
      TY_ENUM: dec_nxt.b = rv;
      default: dec_nxt.b = rv & size_mask(rs);
    endcase
    dec_nxt.any_sig  = (lt == TY_SGN) || (rt == TY_SGN);
    dec_nxt.both_sig = (lt == TY_SGN) && (rt == TY_SGN);
    dec_nxt.sz       = (ls > rs) ? ls : rs;
    if (f_raw > 5'(OP_NOT))
      dec_nxt.undef = 1'b1;
    else if (f_raw == 5'(OP_NOT))
      dec_nxt.undef = (lt != TY_UNS) && (lt != TY_SGN);
    else
      dec_nxt.undef = (lt == TY_BAD) || (rt == TY_BAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_v_r <= 1'b0;
    end else if (en) begin
      dec_v_r <= in_tvalid;
    end
    if (en) dec_r <= dec_nxt;
  end

  // ---------------- execute: simple ops, partial products, magnitudes
  exe_t        exe_nxt, exe_r;
  logic        exe_v_r;
  logic [63:0] ca, cb;
  logic [5:0]  sh;
  logic        big_sh;

  always_comb begin
    ca     = dec_r.a ^ {dec_r.both_sig, 63'd0};
    cb     = dec_r.b ^ {dec_r.both_sig, 63'd0};
    sh     = dec_r.b[5:0];
    big_sh = |dec_r.b[63:6];
    exe_nxt.func    = dec_r.func;
    exe_nxt.any_sig = dec_r.any_sig;
    exe_nxt.sz      = dec_r.sz;
    exe_nxt.undef   = dec_r.undef;
    exe_nxt.divz    = ((dec_r.func == OP_DIV) || (dec_r.func == OP_MOD)) && (dec_r.b == 64'd0);
    exe_nxt.neg_q   = dec_r.any_sig && (dec_r.a[63] ^ dec_r.b[63]);
    exe_nxt.neg_r   = dec_r.any_sig && dec_r.a[63];
    exe_nxt.ma      = exe_nxt.neg_r ? (64'd0 - dec_r.a) : dec_r.a;
    exe_nxt.mb      = (dec_r.any_sig && dec_r.b[63]) ? (64'd0 - dec_r.b) : dec_r.b;
    exe_nxt.pp_ll   = {32'd0, dec_r.a[31:0]} * {32'd0, dec_r.b[31:0]};
    exe_nxt.pp_lh   = 32'(dec_r.a[31:0] * dec_r.b[63:32]);
    exe_nxt.pp_hl   = 32'(dec_r.a[63:32] * dec_r.b[31:0]);
    case (dec_r.func)
      OP_ADD:  exe_nxt.res = dec_r.a + dec_r.b;
      OP_SUB:  exe_nxt.res = dec_r.a - dec_r.b;
      OP_AND:  exe_nxt.res = dec_r.a & dec_r.b;
      OP_OR:   exe_nxt.res = dec_r.a | dec_r.b;
      OP_XOR:  exe_nxt.res = dec_r.a ^ dec_r.b;
      OP_SHR: begin
        if (dec_r.any_sig)
          exe_nxt.res = big_sh ? {64{dec_r.a[63]}} : 64'($signed(dec_r.a) >>> sh);
        else
          exe_nxt.res = big_sh ? 64'd0 : (dec_r.a >> sh);
      end
      OP_SHL:  exe_nxt.res = big_sh ? 64'd0 : (dec_r.a << sh);
      OP_GT:   exe_nxt.res = {63'd0, ca > cb};
      OP_GE:   exe_nxt.res = {63'd0, ca >= cb};
      OP_LT:   exe_nxt.res = {63'd0, ca < cb};
      OP_LE:   exe_nxt.res = {63'd0, ca <= cb};
      OP_EQ:   exe_nxt.res = {63'd0, dec_r.a == dec_r.b};
      OP_LAND: exe_nxt.res = {63'd0, (dec_r.a != 64'd0) && (dec_r.b != 64'd0)};
      OP_LOR:  exe_nxt.res = {63'd0, (dec_r.a != 64'd0) || (dec_r.b != 64'd0)};
      OP_NOT:  exe_nxt.res = {63'd0, dec_r.a == 64'd0};
      default: exe_nxt.res = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exe_v_r <= 1'b0;
    end else if (en) begin
      exe_v_r <= dec_v_r;
    end
    if (en) exe_r <= exe_nxt;
  end

  // ---------------- divider pipeline; first stage also sums the product
  dv_t                  dv_nxt [DIV_STEPS];
  dv_t                  dv_r   [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_v_r;
  dv_t                  dv_init;

  always_comb begin
    dv_init.func    = exe_r.func;
    dv_init.any_sig = exe_r.any_sig;
    dv_init.sz      = exe_r.sz;
    dv_init.undef   = exe_r.undef;
    dv_init.divz    = exe_r.divz;
    dv_init.neg_q   = exe_r.neg_q;
    dv_init.neg_r   = exe_r.neg_r;
    dv_init.res     = (exe_r.func == OP_MUL) ?
                      (exe_r.pp_ll + {exe_r.pp_lh + exe_r.pp_hl, 32'd0}) : exe_r.res;
    dv_init.rem     = 64'd0;
    dv_init.quo     = exe_r.ma;
    dv_init.dvs     = exe_r.mb;
    dv_nxt[0]       = div_step(dv_init);
    for (int k = 1; k < DIV_STEPS; k++) begin
      dv_nxt[k] = div_step(dv_r[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r <= '0;
    end else if (en) begin
      dv_v_r <= {dv_v_r[DIV_STEPS-2:0], exe_v_r};
    end
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) dv_r[k] <= dv_nxt[k];
    end
  end

  // ---------------- result formatting and output register
  dv_t         fin;
  logic [63:0] r_raw;
  logic [71:0] out_nxt;
  logic [71:0] out_tdata_r;
  logic        out_tvalid_r;

  always_comb begin
    fin = dv_r[DIV_STEPS-1];
    case (fin.func)
      OP_DIV:  r_raw = fin.neg_q ? (64'd0 - fin.quo) : fin.quo;
      OP_MOD:  r_raw = fin.neg_r ? (64'd0 - fin.rem) : fin.rem;
      default: r_raw = fin.res;
    endcase
    if (fin.undef) begin
      out_nxt = {1'b0, ST_UNDEF, 4'd1, 1'b0, 64'd0};
    end else if (5'(fin.func) >= 5'(OP_GT)) begin
      out_nxt = {1'b0, ST_OK, 4'd1, 1'b0, fin.res};
    end else if (fin.divz) begin
      out_nxt = {1'b0, ST_DIVZ, fin.sz, fin.any_sig, 64'd0};
    end else begin
      out_nxt = {1'b0, ST_OK, fin.sz, fin.any_sig,
                 fin.any_sig ? sign_ext(r_raw, fin.sz) : (r_raw & size_mask(fin.sz))};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dv_v_r[DIV_STEPS-1];
    end
    if (en) out_tdata_r <= out_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== dv/sized_typed_integer_alu_unit_test.sv =====
// Testbench for the sized typed integer ALU: random and directed operations against a predictor.
`timescale 1ns / 1ps

module sized_typed_integer_alu_unit_test;
  import stia_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic        is_signed;
    logic [3:0]  size;
    logic [1:0]  status;
  } alu_result_t;

  int unsigned fault_count = 0;

  // One line per mismatch, counted
  task automatic report_fault(input string what);
    fault_count++;
    $display("mismatch: %s", what);
  endtask

  // Expected results, oldest first
  class alu_scoreboard;
    alu_result_t pending[$];

    function automatic logic [63:0] mask_of(input int unsigned sz);
      if (sz >= 8) return '1;
      return (64'd1 << (8 * sz)) - 64'd1;
    endfunction

    function automatic logic [63:0] sext(input logic [63:0] v, input int unsigned sz);
      logic [63:0] m;
      m = mask_of(sz);
      if (sz >= 8) return v;
      v = v & m;
      if (v[8 * sz - 1]) v = v | ~m;
      return v;
    endfunction

    function automatic int unsigned fix_size(input logic [3:0] s);
      if (s == 0) return 1;
      if (s > 8) return 8;
      return 32'(s);
    endfunction

    // Work out the result of one operation
    function automatic alu_result_t compute(input logic [4:0] fn, input logic [63:0] lv,
                                            input logic [1:0] lt, input logic [3:0] lsz,
                                            input logic [63:0] rv, input logic [1:0] rt,
                                            input logic [3:0] rsz);
      alu_result_t r;
      int unsigned ls, rs, sz;
      logic [63:0] a, b, x, ma, mb, ca, cb;
      logic any_sig, cmp;
      r = '{64'd0, 1'b0, 4'd1, ST_OK};
      ls = fix_size(lsz);
      rs = fix_size(rsz);
      if (lt == TY_ENUM) ls = 8;
      if (rt == TY_ENUM) rs = 8;
      a = (lt == TY_ENUM) ? lv : (lt == TY_SGN) ? sext(lv, ls) : (lv & mask_of(ls));
      b = (rt == TY_ENUM) ? rv : (rt == TY_SGN) ? sext(rv, rs) : (rv & mask_of(rs));
      if (fn > OP_NOT) begin
        r.status = ST_UNDEF;
      end else if (fn == OP_NOT) begin
        if (lt == TY_UNS || lt == TY_SGN) r.value = {63'd0, a == 64'd0};
        else r.status = ST_UNDEF;
      end else if (lt == TY_BAD || rt == TY_BAD) begin
        r.status = ST_UNDEF;
      end else if (fn <= OP_SHL) begin
        any_sig = (lt == TY_SGN) || (rt == TY_SGN);
        sz = (ls > rs) ? ls : rs;
        x = 64'd0;
        case (fn)
          OP_ADD: x = a + b;
          OP_SUB: x = a - b;
          OP_MUL: x = a * b;
          OP_DIV, OP_MOD: begin
            if (b == 0) begin
              r.status = ST_DIVZ;
            end else if (any_sig) begin
              ma = a[63] ? -a : a;
              mb = b[63] ? -b : b;
              if (fn == OP_MOD) x = a[63] ? -(ma % mb) : ma % mb;
              else x = (a[63] != b[63]) ? -(ma / mb) : ma / mb;
            end else begin
              x = (fn == OP_MOD) ? a % b : a / b;
            end
          end
          OP_AND: x = a & b;
          OP_OR:  x = a | b;
          OP_XOR: x = a ^ b;
          OP_SHR: begin
            if (b >= 64) x = (any_sig && a[63]) ? '1 : '0;
            else if (any_sig) x = $signed(a) >>> b[5:0];
            else x = a >> b[5:0];
          end
          default: x = (b >= 64) ? 64'd0 : a << b[5:0];
        endcase
        r.size = 4'(sz);
        r.is_signed = any_sig;
        if (r.status == ST_OK) r.value = any_sig ? sext(x, sz) : (x & mask_of(sz));
      end else begin
        ca = a;
        cb = b;
        if (lt == TY_SGN && rt == TY_SGN) begin
          ca[63] = ~ca[63];
          cb[63] = ~cb[63];
        end
        case (fn)
          OP_GT:   cmp = ca > cb;
          OP_GE:   cmp = ca >= cb;
          OP_LT:   cmp = ca < cb;
          OP_LE:   cmp = ca <= cb;
          OP_EQ:   cmp = a == b;
          OP_LAND: cmp = (a != 0) && (b != 0);
          default: cmp = (a != 0) || (b != 0);
        endcase
        r.value = {63'd0, cmp};
      end
      return r;
    endfunction

    function void note_input(input logic [151:0] d);
      pending.push_back(compute(d[4:0], d[68:5], d[70:69], d[74:71],
                                d[138:75], d[140:139], d[144:141]));
    endfunction

    task check_result(input logic [71:0] d);
      alu_result_t e;
      if (pending.size() == 0) begin
        report_fault($sformatf("unexpected result %h", d));
        return;
      end
      e = pending.pop_front();
      if (d[63:0] !== e.value)
        report_fault($sformatf("value %h, expected %h", d[63:0], e.value));
      if (d[64] !== e.is_signed)
        report_fault($sformatf("signed %b, expected %b", d[64], e.is_signed));
      if (d[68:65] !== e.size)
        report_fault($sformatf("size %0d, expected %0d", d[68:65], e.size));
      if (d[70:69] !== e.status)
        report_fault($sformatf("status %0d, expected %0d", d[70:69], e.status));
    endtask
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;
  logic         stim_done = 1'b0;

  alu_scoreboard board = new();

  always #1 clk = ~clk;

  sized_typed_integer_alu_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Operand value biased towards edges
  function automatic logic [63:0] pick_value();
    case ($urandom_range(7))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'($urandom_range(70));
      4: return 64'd1 << $urandom_range(63);
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [1:0] pick_type();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 40) return TY_UNS;
    if (p < 80) return TY_SGN;
    if (p < 95) return TY_ENUM;
    return TY_BAD;
  endfunction

  function automatic logic [3:0] pick_size();
    return ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1));
  endfunction

  // One transaction on the input side
  task automatic send_op(input logic [4:0] fn, input logic [63:0] lv, input logic [1:0] lt,
                         input logic [3:0] ls, input logic [63:0] rv, input logic [1:0] rt,
                         input logic [3:0] rs);
    int unsigned g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, rs, rt, rv, ls, lt, lv, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Input bookkeeping at each accepted transaction, output checking at each accepted result
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  // Output back-pressure
  initial begin
    int unsigned g;
    @(posedge clk);
    out_tready <= 1'b1;
    forever begin
      g = pick_gap();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
        out_tready <= 1'b1;
      end
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  end

  // Stimulus
  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: every operation, extremes and special cases
    for (i = 0; i <= OP_NOT; i++)
      send_op(5'(i), 64'hFFFF_FFFF_FFFF_FFFF, TY_SGN, 4'd2, 64'h0000_0000_0000_0003,
              TY_UNS, 4'd8);
    send_op(OP_DIV, 64'h8000_0000_0000_0000, TY_SGN, 4'd8, '1, TY_SGN, 4'd8);
    send_op(OP_MOD, 64'h8000_0000_0000_0000, TY_SGN, 4'd8, '1, TY_SGN, 4'd8);
    send_op(OP_DIV, 64'd5, TY_UNS, 4'd1, 64'd0, TY_UNS, 4'd0);
    send_op(OP_SHR, 64'h80, TY_SGN, 4'd1, 64'd64, TY_ENUM, 4'd15);
    send_op(OP_SHL, '1, TY_UNS, 4'd8, 64'd100, TY_UNS, 4'd8);
    send_op(OP_NOT, 64'd0, TY_ENUM, 4'd1, '1, TY_BAD, 4'd1);
    send_op(OP_ADD, '1, TY_BAD, 4'd4, 64'd1, TY_UNS, 4'd1);
    send_op(5'd31, '1, TY_UNS, 4'd9, '1, TY_UNS, 4'd0);
    // random part
    for (i = 0; i < 1700; i++)
      send_op(($urandom_range(19) == 0) ? 5'($urandom_range(31, 18))
                                        : 5'($urandom_range(OP_NOT)),
              pick_value(), pick_type(), pick_size(), pick_value(), pick_type(), pick_size());
    in_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    stim_done <= 1'b1;
  end

  // Final verdict
  initial begin
    wait (stim_done);
    if (fault_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
